@@ src/sfa_pkg.sv @@
// shared types and constants of the stack frame allocator
package sfa_pkg;

  // payload field widths
  localparam int unsigned OP_W    = 3;
  localparam int unsigned REQ_W   = 7;
  localparam int unsigned ALOG_W  = 3;
  localparam int unsigned MARK_W  = 13;
  localparam int unsigned ADDR_W  = 12;
  localparam int unsigned OFS_W   = 13;
  localparam int unsigned ADJ_W   = 14;
  localparam int unsigned BYTES_W = 13;
  localparam int unsigned ERR_W   = 3;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 3'd0,
    OP_FREE  = 3'd1,
    OP_ENTER = 3'd2,
    OP_EXIT  = 3'd3,
    OP_RESET = 3'd4
  } sfa_op_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK         = 3'd0,
    ERR_BAD_ALIGN  = 3'd1,
    ERR_FRAME_FULL = 3'd2,
    ERR_MARK_ABOVE = 3'd3,
    ERR_NO_SCOPE   = 3'd4,
    ERR_SCOPE_FULL = 3'd5
  } sfa_err_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic eval;
    logic start;
    logic commit;
  } sfa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_rem;
    logic rem_done;
  } sfa_stat_t;

endpackage

@@ src/sfa_if.sv @@
// request and response channel interfaces of the stack frame allocator
interface sfa_req_if;
  logic                          valid;
  logic                          ready;
  logic [sfa_pkg::OP_W-1:0]      operation;
  logic [sfa_pkg::REQ_W-1:0]     request_bytes;
  logic [sfa_pkg::ALOG_W-1:0]    align_log2;
  logic [sfa_pkg::MARK_W-1:0]    free_mark;

  modport source (output valid, output operation, output request_bytes,
                  output align_log2, output free_mark, input ready);
  modport sink   (input valid, input operation, input request_bytes,
                  input align_log2, input free_mark, output ready);
endinterface

interface sfa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [sfa_pkg::ADDR_W-1:0]    address;
  logic [sfa_pkg::OFS_W-1:0]     top_offset;
  logic signed [sfa_pkg::ADJ_W-1:0] sp_adjust;
  logic                          sp_moved;
  logic [sfa_pkg::BYTES_W-1:0]   frame_bytes;
  logic [sfa_pkg::BYTES_W-1:0]   used_bytes;
  logic [sfa_pkg::ERR_W-1:0]     error_code;

  modport source (output valid, output address, output top_offset, output sp_adjust,
                  output sp_moved, output frame_bytes, output used_bytes,
                  output error_code, input ready);
  modport sink   (input valid, input address, input top_offset, input sp_adjust,
                  input sp_moved, input frame_bytes, input used_bytes,
                  input error_code, output ready);
endinterface

@@ src/sfa_rem.sv @@
// remainder of a value by the constant block size, by reciprocal multiplication
module sfa_rem #(
  parameter int unsigned DW      = 14,
  parameter int unsigned DIVISOR = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [DW-1:0]            value_i,
  output logic                     idle_o,
  output logic [$clog2(DIVISOR):0] rem_o
);

  localparam int unsigned     RW    = $clog2(DIVISOR) + 1;
  localparam int unsigned     SH    = DW + $clog2(DIVISOR);
  localparam longint unsigned RECIP = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam int unsigned     MW    = $clog2(RECIP + 1);
  localparam int unsigned     PW    = DW + MW;

  logic [1:0]    cnt_q, cnt_d;
  logic [DW-1:0] value_q;
  logic [DW-1:0] quot_q;
  logic [RW-1:0] rem_q;
  logic [PW-1:0] prod;
  logic [DW-1:0] quot_d;
  logic [DW-1:0] back;
  logic [RW-1:0] rem_d;

  // quotient by scaled reciprocal, exact over the whole input range
  assign prod   = PW'(value_q) * PW'(RECIP);
  assign quot_d = DW'(prod >> SH);
  // second stage: remainder from the quotient
  assign back   = quot_q * DW'(DIVISOR);
  assign rem_d  = RW'(value_q - back);

  always_comb begin
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = 2'd2;
    end else if (cnt_q != 2'd0) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      value_q <= value_i;
    end
    if (cnt_q == 2'd2) begin
      quot_q <= quot_d;
    end
    if (cnt_q == 2'd1) begin
      rem_q <= rem_d;
    end
  end

  assign idle_o = (cnt_q == 2'd0);
  assign rem_o  = rem_q;

endmodule

@@ src/sfa_ctrl.sv @@
// sequencing state machine and response valid of the stack frame allocator
module sfa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  input  sfa_pkg::sfa_stat_t stat_i,
  output sfa_pkg::sfa_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EVAL   = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_COMMIT = 4'b1000
  } sfa_state_e;

  sfa_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign slot_free  = !out_valid_q || out_ready_i;

  assign cmd_o.load   = in_valid_i && in_ready_o;
  assign cmd_o.eval   = (state_q == ST_EVAL);
  assign cmd_o.start  = (state_q == ST_EVAL) && stat_i.need_rem;
  assign cmd_o.commit = (state_q == ST_COMMIT) && slot_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        state_d = stat_i.need_rem ? ST_DIV : ST_COMMIT;
      end
      ST_DIV: begin
        if (stat_i.rem_done) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ src/sfa_dp.sv @@
// frame state, scope mark memory and arithmetic of the stack frame allocator
module sfa_dp #(
  parameter int unsigned BLOCK_BYTES = 16,
  parameter int unsigned FRAME_LIMIT = 4096,
  parameter int unsigned SCOPE_DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  sfa_pkg::sfa_cmd_t                cmd_i,
  output sfa_pkg::sfa_stat_t               stat_o,
  input  logic [sfa_pkg::OP_W-1:0]         operation_i,
  input  logic [sfa_pkg::REQ_W-1:0]        request_bytes_i,
  input  logic [sfa_pkg::ALOG_W-1:0]       align_log2_i,
  input  logic [sfa_pkg::MARK_W-1:0]       free_mark_i,
  output logic [sfa_pkg::ADDR_W-1:0]       address_o,
  output logic [sfa_pkg::OFS_W-1:0]        top_offset_o,
  output logic signed [sfa_pkg::ADJ_W-1:0] sp_adjust_o,
  output logic                             sp_moved_o,
  output logic [sfa_pkg::BYTES_W-1:0]      frame_bytes_o,
  output logic [sfa_pkg::BYTES_W-1:0]      used_bytes_o,
  output logic [sfa_pkg::ERR_W-1:0]        error_code_o
);

  localparam int unsigned W    = $clog2(FRAME_LIMIT + 1);
  localparam int unsigned DW   = (W + 2 > 14) ? W + 2 : 14;
  localparam int unsigned CNTW = $clog2(SCOPE_DEPTH + 1);
  localparam int unsigned IW   = $clog2(SCOPE_DEPTH);
  localparam int unsigned RW   = $clog2(BLOCK_BYTES) + 1;

  // frame state
  logic [W-1:0]    usage_q, frame_q;
  logic [CNTW-1:0] count_q;
  logic [W-1:0]    marks_mem [SCOPE_DEPTH];

  // latched request and evaluation results
  logic [sfa_pkg::OP_W-1:0]   op_q;
  logic [sfa_pkg::REQ_W-1:0]  req_q;
  logic [sfa_pkg::ALOG_W-1:0] alog_q;
  logic [sfa_pkg::MARK_W-1:0] fmark_q;
  logic [W-1:0]               mark_q;
  logic [DW-1:0]              base_q, need_q, val_q;
  logic                       grow_q;
  sfa_pkg::sfa_err_e          err_q;

  // evaluate step
  logic [DW-1:0]     usage_x, frame_x, fmark_x, mark_x, req_x;
  logic [DW-1:0]     align_x, mask_x, base_e, need_e, val_e;
  logic              grow_e, bad_align;
  sfa_pkg::sfa_err_e err_e;
  logic [CNTW-1:0]   cnt_m1;
  logic [IW-1:0]     rd_idx;

  // commit step
  logic              rem_idle;
  logic [RW-1:0]     rem_r;
  logic [DW-1:0]     span, newframe;
  logic              full;
  sfa_pkg::sfa_err_e err_c;
  logic [DW-1:0]     usage_n, frame_n, addr_c;
  logic [CNTW-1:0]   count_n;
  logic signed [DW:0] adj_c;
  logic              wr_en;

  assign usage_x = DW'(usage_q);
  assign frame_x = DW'(frame_q);
  assign fmark_x = DW'(fmark_q);
  assign mark_x  = DW'(mark_q);
  assign req_x   = DW'(req_q);

  assign align_x = DW'(1) << alog_q;
  assign mask_x  = align_x - DW'(1);
  assign base_e  = (usage_x + mask_x) & ~mask_x;
  assign need_e  = base_e + req_x;
  assign grow_e  = need_e > frame_x;
  // a divisor of a power of two is itself a power of two
  assign bad_align = (req_q == '0) || ((req_q & (req_q - sfa_pkg::REQ_W'(1))) != '0)
                     || (req_x > align_x);

  always_comb begin
    val_e = '0;
    err_e = sfa_pkg::ERR_OK;
    case (op_q)
      sfa_pkg::OP_ALLOC: begin
        val_e = need_e - frame_x + DW'(BLOCK_BYTES - 1);
        if (bad_align) err_e = sfa_pkg::ERR_BAD_ALIGN;
      end
      sfa_pkg::OP_FREE: begin
        val_e = frame_x - fmark_x;
        if (fmark_x > usage_x) err_e = sfa_pkg::ERR_MARK_ABOVE;
      end
      sfa_pkg::OP_ENTER: begin
        if (count_q >= CNTW'(SCOPE_DEPTH)) err_e = sfa_pkg::ERR_SCOPE_FULL;
      end
      sfa_pkg::OP_EXIT: begin
        val_e = frame_x - mark_x;
        if (count_q == '0) begin
          err_e = sfa_pkg::ERR_NO_SCOPE;
        end else if (mark_x > usage_x) begin
          err_e = sfa_pkg::ERR_MARK_ABOVE;
        end
      end
      default: begin
        val_e = '0;
      end
    endcase
  end

  assign stat_o.need_rem = (err_e == sfa_pkg::ERR_OK) &&
                           (((op_q == sfa_pkg::OP_ALLOC) && grow_e) ||
                            (op_q == sfa_pkg::OP_FREE) || (op_q == sfa_pkg::OP_EXIT));
  assign stat_o.rem_done = rem_idle;

  sfa_rem #(
    .DW      (DW),
    .DIVISOR (BLOCK_BYTES)
  ) u_rem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start),
    .value_i (val_e),
    .idle_o  (rem_idle),
    .rem_o   (rem_r)
  );

  // whole blocks of the value: growth for alloc, release for free and exit
  assign span     = val_q - DW'(rem_r);
  assign newframe = grow_q ? (frame_x + span) : frame_x;
  assign full     = newframe > DW'(FRAME_LIMIT);

  always_comb begin
    err_c = err_q;
    if ((err_q == sfa_pkg::ERR_OK) && (op_q == sfa_pkg::OP_ALLOC) && full) begin
      err_c = sfa_pkg::ERR_FRAME_FULL;
    end
  end

  always_comb begin
    usage_n = usage_x;
    frame_n = frame_x;
    count_n = count_q;
    addr_c  = '0;
    adj_c   = '0;
    wr_en   = 1'b0;
    if (err_c == sfa_pkg::ERR_OK) begin
      case (op_q)
        sfa_pkg::OP_ALLOC: begin
          frame_n = newframe;
          usage_n = need_q;
          addr_c  = base_q;
          adj_c   = $signed({1'b0, newframe - frame_x});
        end
        sfa_pkg::OP_FREE: begin
          usage_n = fmark_x;
          frame_n = frame_x - span;
          adj_c   = -$signed({1'b0, span});
        end
        sfa_pkg::OP_ENTER: begin
          wr_en   = 1'b1;
          count_n = count_q + CNTW'(1);
        end
        sfa_pkg::OP_EXIT: begin
          usage_n = mark_x;
          frame_n = frame_x - span;
          adj_c   = -$signed({1'b0, span});
          count_n = count_q - CNTW'(1);
        end
        sfa_pkg::OP_RESET: begin
          usage_n = '0;
          frame_n = '0;
          count_n = '0;
          adj_c   = -$signed({1'b0, frame_x});
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  assign cnt_m1 = count_q - CNTW'(1);
  assign rd_idx = cnt_m1[IW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usage_q <= '0;
      frame_q <= '0;
      count_q <= '0;
    end else if (cmd_i.commit) begin
      usage_q <= W'(usage_n);
      frame_q <= W'(frame_n);
      count_q <= count_n;
    end
  end

  // scope mark memory, read of the top mark on request transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_en) begin
      marks_mem[count_q[IW-1:0]] <= usage_q;
    end
    if (cmd_i.load) begin
      mark_q <= marks_mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= operation_i;
      req_q   <= request_bytes_i;
      alog_q  <= align_log2_i;
      fmark_q <= free_mark_i;
    end
    if (cmd_i.eval) begin
      base_q <= base_e;
      need_q <= need_e;
      grow_q <= grow_e;
      val_q  <= val_e;
      err_q  <= err_e;
    end
    if (cmd_i.commit) begin
      address_o     <= addr_c[sfa_pkg::ADDR_W-1:0];
      top_offset_o  <= sfa_pkg::OFS_W'(frame_n - addr_c);
      sp_adjust_o   <= adj_c[sfa_pkg::ADJ_W-1:0];
      sp_moved_o    <= (adj_c != '0);
      frame_bytes_o <= sfa_pkg::BYTES_W'(frame_n);
      used_bytes_o  <= sfa_pkg::BYTES_W'(usage_n);
      error_code_o  <= err_c;
    end
  end

endmodule

@@ src/stack_frame_allocator_unit.sv @@
// top level of the stack frame bump allocator with scope marks
//
// Stack frame bump allocator. Each request transfer carries one operation (alloc,
// free to mark, enter scope, exit scope, reset frame) and gives exactly one
// response transfer with the allocated address, the offset from the frame top,
// the stack pointer adjustment, the new frame size and usage, and an error
// code; a failed request leaves the state untouched. One request is in work at
// a time: a request that needs no block rounding goes from its transfer through
// the evaluate and commit states, and the response is registered at commit. An
// alloc that grows the frame, and every free or scope exit that is not refused,
// first rounds the size change to whole blocks with a two-stage reciprocal
// multiplication by BLOCK_BYTES between evaluate and commit. The response sits
// in an output register, so the next request is taken while it waits; its commit
// waits until that earlier response has gone, so a stalled response side adds
// its stall cycles. The scope mark memory needs no clearing after reset.
module stack_frame_allocator_unit #(
  parameter int unsigned BLOCK_BYTES = 16,
  parameter int unsigned FRAME_LIMIT = 4096,
  parameter int unsigned SCOPE_DEPTH = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  sfa_req_if.sink   req_i,
  sfa_rsp_if.source rsp_o
);

  sfa_pkg::sfa_cmd_t  cmd;
  sfa_pkg::sfa_stat_t stat;

  // sequencing: request transfer, evaluate, optional remainder, commit
  sfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // frame state, mark memory and response register
  sfa_dp #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .FRAME_LIMIT (FRAME_LIMIT),
    .SCOPE_DEPTH (SCOPE_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .operation_i     (req_i.operation),
    .request_bytes_i (req_i.request_bytes),
    .align_log2_i    (req_i.align_log2),
    .free_mark_i     (req_i.free_mark),
    .address_o       (rsp_o.address),
    .top_offset_o    (rsp_o.top_offset),
    .sp_adjust_o     (rsp_o.sp_adjust),
    .sp_moved_o      (rsp_o.sp_moved),
    .frame_bytes_o   (rsp_o.frame_bytes),
    .used_bytes_o    (rsp_o.used_bytes),
    .error_code_o    (rsp_o.error_code)
  );

  // one request in work at a time
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while another is in work");

  // a refused request moves nothing and places nothing
  a_error_no_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.error_code != sfa_pkg::ERR_OK))
      |-> (!rsp_o.sp_moved && (rsp_o.address == '0)))
    else $error("error response with a stack pointer move or an address");

  // usage never runs past the frame
  a_usage_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> ((FRAME_LIMIT >= 8192) || (rsp_o.used_bytes <= rsp_o.frame_bytes)))
    else $error("usage above frame size");

endmodule
